FILE: hdl/prft_pkg.sv
// Package for the threshold-crossing pulse rate meter.
// Holds the sequencer state type, register indexes and fixed constants.
// No dependencies.
package prft_pkg;

  localparam int unsigned RATE_BITS = 24;
  localparam int unsigned SAMPLE_FIELD_BITS = 12;
  localparam int unsigned TIME_FIELD_BITS = 32;
  localparam int unsigned THR_BITS = 12;
  localparam int unsigned DEB_BITS = 16;
  localparam int unsigned CNT_BITS = 5;

  localparam logic [RATE_BITS-1:0] RATE_NUMERATOR_Q8 = 24'd15360000;
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 12'd600;
  localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET = 16'd50;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } prft_state_t;

endpackage

FILE: hdl/pulse_rate_from_threshold.sv
// Threshold-crossing pulse rate meter, top level.
// Uses prft_pkg for the state type, register indexes and constants.
//
// The input channel carries one ADC sample and its millisecond time stamp per
// transfer. Each accepted sample yields exactly one result transfer with the
// current rate in Q8, the high flag, a beat flag and a rate-updated flag.
// A sample is evaluated only when more than debounce_ms have passed since the
// last evaluation; a rising crossing of the threshold is a beat, and a second
// beat starts a restoring division of 15360000 by the beat interval.
// The divider's single subtractor forms one quotient bit per cycle until all 24
// quotient bits are formed. in_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next sample is accepted while
// a finished result still waits; if the receiver stalls for longer, the
// sequencer holds its result until the output register frees up.
// Configuration is written over the APB port; the user must do this only while
// the block is idle, since the block itself does not enforce it.
// Reset is synchronous and active low; it restores the register defaults
// (threshold 600, debounce 50) and clears all beat and rate state.
module pulse_rate_from_threshold
  import prft_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // sample [11:0], now_ms [43:12], zero [47:44]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // heart_rate_q8 [23:0], pulse_high [24],
                                   // beat [25], rate_updated [26], zero [31:27]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = (SAMPLE_BITS < SAMPLE_FIELD_BITS) ? SAMPLE_BITS
                                                                  : SAMPLE_FIELD_BITS;
  localparam int unsigned TW = TIME_BITS;
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(RATE_BITS - 1);

  prft_state_t         state_r, state_nxt;
  logic [THR_BITS-1:0] thr_r, thr_nxt;
  logic [DEB_BITS-1:0] deb_r, deb_nxt;
  logic [SW-1:0]       sample_r, sample_nxt;
  logic [TW-1:0]       now_r, now_nxt;
  logic [TW-1:0]       last_eval_r, last_eval_nxt;
  logic [TW-1:0]       last_beat_r, last_beat_nxt;
  logic                have_beat_r, have_beat_nxt;
  logic                high_r, high_nxt;
  logic [RATE_BITS-1:0] rate_r, rate_nxt;
  logic                beat_r, beat_nxt;
  logic                upd_r, upd_nxt;
  logic [TW-1:0]       den_r, den_nxt;
  logic [TW-1:0]       rem_r, rem_nxt;
  logic [RATE_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [31:0]         out_tdata_r, out_tdata_nxt;

  logic                cfg_wr;
  logic [TW-1:0]       elapsed;
  logic [TW-1:0]       interval;
  logic [THR_BITS-1:0] sample_ext;
  logic [TW:0]         trial;
  logic [TW:0]         diff;
  logic                out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_DEBOUNCE) ? 32'(deb_r) : 32'(thr_r);

  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_free = !out_tvalid_r || out_tready;

  assign elapsed = now_r - last_eval_r;
  assign interval = now_r - last_beat_r;
  assign sample_ext = THR_BITS'(sample_r);
  assign trial = {rem_r, quo_r[RATE_BITS-1]};
  assign diff = trial - {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    thr_nxt = thr_r;
    deb_nxt = deb_r;
    sample_nxt = sample_r;
    now_nxt = now_r;
    last_eval_nxt = last_eval_r;
    last_beat_nxt = last_beat_r;
    have_beat_nxt = have_beat_r;
    high_nxt = high_r;
    rate_nxt = rate_r;
    beat_nxt = beat_r;
    upd_nxt = upd_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_wr) begin
      if (paddr[2] == REG_THRESHOLD) begin
        thr_nxt = pwdata[THR_BITS-1:0];
      end else begin
        deb_nxt = pwdata[DEB_BITS-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata[SW-1:0];
          now_nxt = in_tdata[SAMPLE_FIELD_BITS +: TW];
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        beat_nxt = 1'b0;
        upd_nxt = 1'b0;
        state_nxt = ST_OUT;
        if (elapsed > TW'(deb_r)) begin
          last_eval_nxt = now_r;
          if ((sample_ext > thr_r) && !high_r) begin
            high_nxt = 1'b1;
            beat_nxt = 1'b1;
            last_beat_nxt = now_r;
            have_beat_nxt = 1'b1;
            if (have_beat_r && (interval != '0)) begin
              den_nxt = interval;
              rem_nxt = '0;
              quo_nxt = RATE_NUMERATOR_Q8;
              cnt_nxt = '0;
              state_nxt = ST_DIV;
            end
          end else if (sample_ext < thr_r) begin
            high_nxt = 1'b0;
          end
        end
      end
      ST_DIV: begin
        if (!diff[TW]) begin
          rem_nxt = diff[TW-1:0];
        end else begin
          rem_nxt = trial[TW-1:0];
        end
        quo_nxt = {quo_r[RATE_BITS-2:0], !diff[TW]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          rate_nxt = {quo_r[RATE_BITS-2:0], !diff[TW]};
          upd_nxt = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt = {5'b0, upd_r, beat_r, high_r, rate_r};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      thr_r <= THRESHOLD_RESET;
      deb_r <= DEBOUNCE_RESET;
      last_eval_r <= '0;
      last_beat_r <= '0;
      have_beat_r <= 1'b0;
      high_r <= 1'b0;
      rate_r <= '0;
      beat_r <= 1'b0;
      upd_r <= 1'b0;
      cnt_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      thr_r <= thr_nxt;
      deb_r <= deb_nxt;
      last_eval_r <= last_eval_nxt;
      last_beat_r <= last_beat_nxt;
      have_beat_r <= have_beat_nxt;
      high_r <= high_nxt;
      rate_r <= rate_nxt;
      beat_r <= beat_nxt;
      upd_r <= upd_nxt;
      cnt_r <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    now_r <= now_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
